// ===== sv/lpsce_pkg.sv =====
// Shared types, codes and constants of the LED pixel SPI code encoder.
package lpsce_pkg;

  // Largest number of LEDs the buffer is laid out for
  localparam int unsigned MaxLeds = 1024;

  localparam int unsigned IndexW  = 10;
  localparam int unsigned ColourW = 8;
  localparam int unsigned OffsetW = 15;
  localparam int unsigned CountW  = 11;
  localparam int unsigned BeatW   = 5;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDatW = 11;

  // SPI byte sent for a zero bit
  localparam logic [ColourW-1:0] ZeroCode = 8'hC0;

  // Register reset values
  localparam logic [ColourW-1:0] OneCodeReset  = 8'hF8;
  localparam logic [CountW-1:0]  LedCountReset = CountW'(MaxLeds);

  // Last beat number of each run length
  localparam logic [BeatW-1:0] LastBeatErr  = 5'd0;
  localparam logic [BeatW-1:0] LastBeatRaw  = 5'd2;
  localparam logic [BeatW-1:0] LastBeatWire = 5'd23;
  localparam logic [BeatW-1:0] LastBeatGrbw = 5'd31;

  typedef enum logic [1:0] {
    StripRawRgb   = 2'd0,
    StripWireRgb  = 2'd1,
    StripWireGrb  = 2'd2,
    StripWireGrbw = 2'd3
  } strip_type_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgStripType = 2'd0,
    CfgOneBitCode = 2'd1,
    CfgLedCount  = 2'd2
  } cfg_index_e;

  // Configuration as seen by the datapath
  typedef struct packed {
    strip_type_e        strip;
    logic [ColourW-1:0] one_code;
    logic [CountW-1:0]  led_count;
  } cfg_t;

  // One accepted pixel with the settings it was taken under
  typedef struct packed {
    logic [IndexW-1:0]  led_index;
    logic [ColourW-1:0] red;
    logic [ColourW-1:0] green;
    logic [ColourW-1:0] blue;
    logic [ColourW-1:0] white;
    strip_type_e        strip;
    logic [ColourW-1:0] one_code;
    logic               err;
  } item_t;

  // Current output beat of the run
  typedef struct packed {
    logic             valid;
    logic [BeatW-1:0] beat;
    logic             last;
  } beat_t;

endpackage

// ===== sv/lpsce_cfg_regs.sv =====
// Configuration register file of the LED pixel SPI code encoder.
module lpsce_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpsce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpsce_pkg::CfgDatW-1:0]  cfg_data_i,
  output lpsce_pkg::cfg_t                cfg_o
);
  import lpsce_pkg::*;

  strip_type_e        strip_q;
  logic [ColourW-1:0] one_code_q;
  logic [CountW-1:0]  led_count_q;
  logic               wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i & cfg_ready_o;

  // Take a write transaction; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      strip_q     <= StripWireRgb;
      one_code_q  <= OneCodeReset;
      led_count_q <= LedCountReset;
    end else if (wr_en) begin
      case (cfg_index_e'(cfg_index_i))
        CfgStripType:  strip_q     <= strip_type_e'(cfg_data_i[1:0]);
        CfgOneBitCode: one_code_q  <= cfg_data_i[ColourW-1:0];
        CfgLedCount:   led_count_q <= cfg_data_i[CountW-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = '{strip: strip_q, one_code: one_code_q, led_count: led_count_q};

endmodule

// ===== sv/lpsce_beat_seq.sv =====
// Input register and output beat counter of the LED pixel SPI code encoder.
module lpsce_beat_seq (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpsce_pkg::IndexW-1:0]   led_index_i,
  input  logic [lpsce_pkg::ColourW-1:0]  red_i,
  input  logic [lpsce_pkg::ColourW-1:0]  green_i,
  input  logic [lpsce_pkg::ColourW-1:0]  blue_i,
  input  logic [lpsce_pkg::ColourW-1:0]  white_i,
  input  lpsce_pkg::cfg_t                cfg_i,
  output lpsce_pkg::item_t               item_o,
  output lpsce_pkg::beat_t               beat_o
);
  import lpsce_pkg::*;

  item_t            item_q, item_d;
  logic             active_q, active_d;
  logic [BeatW-1:0] beat_q, beat_d;
  logic [BeatW-1:0] last_beat_q, last_beat_d;
  logic             at_last;
  logic             accept;
  logic             idx_bad;

  assign at_last = (beat_q == last_beat_q);
  assign busy    = active_q & ~at_last;
  assign accept  = start & ~busy;

  // Reject indexes past the strip or the buffer
  assign idx_bad = ({1'b0, led_index_i} >= cfg_i.led_count) ||
                   ({1'b0, led_index_i} >= CountW'(MaxLeds));

  // Load a new pixel or advance through the current run
  always_comb begin
    item_d      = item_q;
    active_d    = active_q;
    beat_d      = beat_q;
    last_beat_d = last_beat_q;
    if (accept) begin
      item_d = '{led_index: led_index_i, red: red_i, green: green_i, blue: blue_i,
                 white: white_i, strip: cfg_i.strip, one_code: cfg_i.one_code,
                 err: idx_bad};
      active_d = 1'b1;
      beat_d   = '0;
      if (idx_bad) begin
        last_beat_d = LastBeatErr;
      end else begin
        case (cfg_i.strip)
          StripRawRgb:   last_beat_d = LastBeatRaw;
          StripWireGrbw: last_beat_d = LastBeatGrbw;
          default:       last_beat_d = LastBeatWire;
        endcase
      end
    end else if (active_q) begin
      if (at_last) begin
        active_d = 1'b0;
      end else begin
        beat_d = beat_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      beat_q      <= '0;
      last_beat_q <= '0;
    end else begin
      active_q    <= active_d;
      beat_q      <= beat_d;
      last_beat_q <= last_beat_d;
    end
  end

  // Pixel payload holds no reset
  always_ff @(posedge clk_i) begin
    item_q <= item_d;
  end

  assign item_o = item_q;
  assign beat_o = '{valid: active_q, beat: beat_q, last: at_last};

  a_accept_starts_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (active_q && beat_q == '0))
    else $error("accepted pixel did not start at beat zero");

  a_beat_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (beat_q <= last_beat_q))
    else $error("beat counter ran past end of run");

  a_error_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (active_q && item_q.err) |-> (last_beat_q == LastBeatErr))
    else $error("rejected index produced more than one result");

endmodule

// ===== sv/lpsce_code_gen.sv =====
// Byte and offset encoder with result register of the LED pixel SPI code encoder.
module lpsce_code_gen (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lpsce_pkg::item_t               item_i,
  input  lpsce_pkg::beat_t               beat_i,
  output logic                           result_valid_o,
  output logic [lpsce_pkg::OffsetW-1:0]  byte_offset_o,
  output logic [lpsce_pkg::ColourW-1:0]  code_byte_o,
  output logic                           last_of_run_o,
  output logic                           index_error_o
);
  import lpsce_pkg::*;

  logic [OffsetW-1:0] idx_w, base3, base24, base32, base, offset_d;
  logic [ColourW-1:0] colour, byte_d;
  logic [1:0]         slot;
  logic [2:0]         bit_pos;
  logic               valid_q;
  logic [OffsetW-1:0] offset_q;
  logic [ColourW-1:0] byte_q;
  logic               last_q, err_q;

  assign slot    = beat_i.beat[4:3];
  assign bit_pos = beat_i.beat[2:0];

  // Pixel base offsets for the three strides
  assign idx_w  = OffsetW'(item_i.led_index);
  assign base3  = (idx_w << 1) + idx_w;
  assign base24 = base3 << 3;
  assign base32 = idx_w << 5;

  // Pick the colour of the current slot in wire order
  always_comb begin
    case (item_i.strip)
      StripWireRgb: begin
        case (slot)
          2'd0:    colour = item_i.red;
          2'd1:    colour = item_i.green;
          default: colour = item_i.blue;
        endcase
      end
      default: begin
        case (slot)
          2'd0:    colour = item_i.green;
          2'd1:    colour = item_i.red;
          2'd2:    colour = item_i.blue;
          default: colour = item_i.white;
        endcase
      end
    endcase
  end

  // Form the byte and its buffer position for this beat
  always_comb begin
    case (item_i.strip)
      StripRawRgb:   base = base3;
      StripWireGrbw: base = base32;
      default:       base = base24;
    endcase
    offset_d = base + OffsetW'(beat_i.beat);
    if (item_i.strip == StripRawRgb) begin
      case (beat_i.beat[1:0])
        2'd0:    byte_d = item_i.red;
        2'd1:    byte_d = item_i.green;
        default: byte_d = item_i.blue;
      endcase
    end else begin
      byte_d = colour[3'd7 - bit_pos] ? item_i.one_code : ZeroCode;
    end
    if (item_i.err) begin
      offset_d = '0;
      byte_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= beat_i.valid;
    end
  end

  // Result payload holds no reset
  always_ff @(posedge clk_i) begin
    offset_q <= offset_d;
    byte_q   <= byte_d;
    last_q   <= beat_i.last;
    err_q    <= item_i.err;
  end

  assign result_valid_o = valid_q;
  assign byte_offset_o  = offset_q;
  assign code_byte_o    = byte_q;
  assign last_of_run_o  = last_q;
  assign index_error_o  = err_q;

  a_error_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && err_q) |-> (last_q && offset_q == '0 && byte_q == '0))
    else $error("error result not a single empty final result");

  a_beat_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    beat_i.valid |=> valid_q)
    else $error("active beat produced no result");

  a_offset_steps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && !last_q && $past(beat_i.valid)) |=>
      (valid_q && byte_offset_o == $past(byte_offset_o) + 1'b1))
    else $error("offsets within a run are not consecutive");

endmodule

// ===== sv/led_pixel_spi_code_encoder.sv =====
// Top level of the LED pixel SPI code encoder.
// One pixel write (start with busy low) becomes a run of SPI buffer bytes, one
// result per cycle on result_valid_o, the first once the write has passed the beat
// register and the result register. A run is 3 results in clocked RGB mode, 24 in
// one-wire RGB and GRB, 32 in one-wire GRBW, and a single result with index_error_o
// set for an index at or past the LED count. The beat counter emits one byte a
// cycle; busy drops during the final beat of a run, and the next pixel then follows
// without a gap. Results cannot be held off: the receiver must take each one in the
// cycle it appears. Configuration is written through the cfg channel, which is
// always ready; it is up to the user to write it only while no run is active.
module led_pixel_spi_code_encoder (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start,
  output logic                           busy,
  input  logic [lpsce_pkg::IndexW-1:0]   led_index_i,
  input  logic [lpsce_pkg::ColourW-1:0]  red_i,
  input  logic [lpsce_pkg::ColourW-1:0]  green_i,
  input  logic [lpsce_pkg::ColourW-1:0]  blue_i,
  input  logic [lpsce_pkg::ColourW-1:0]  white_i,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [lpsce_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [lpsce_pkg::CfgDatW-1:0]  cfg_data_i,
  output logic                           result_valid_o,
  output logic [lpsce_pkg::OffsetW-1:0]  byte_offset_o,
  output logic [lpsce_pkg::ColourW-1:0]  code_byte_o,
  output logic                           last_of_run_o,
  output logic                           index_error_o
);
  import lpsce_pkg::*;

  cfg_t  cfg;
  item_t item;
  beat_t beat;

  lpsce_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  lpsce_beat_seq u_beat_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .led_index_i (led_index_i),
    .red_i       (red_i),
    .green_i     (green_i),
    .blue_i      (blue_i),
    .white_i     (white_i),
    .cfg_i       (cfg),
    .item_o      (item),
    .beat_o      (beat)
  );

  lpsce_code_gen u_code_gen (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .item_i         (item),
    .beat_i         (beat),
    .result_valid_o (result_valid_o),
    .byte_offset_o  (byte_offset_o),
    .code_byte_o    (code_byte_o),
    .last_of_run_o  (last_of_run_o),
    .index_error_o  (index_error_o)
  );

endmodule
